// ===== rtl/pp20_pkg.sv =====
`default_nettype none
package pp20_pkg;

    localparam int WINDOW_DEPTH    = 32768;
    localparam int MAX_OFFSET_BITS = 15;

    localparam int WIN_AW  = $clog2(WINDOW_DEPTH);
    localparam int WR_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int ACC_W   = (MAX_OFFSET_BITS > 8) ? MAX_OFFSET_BITS : 8;
    localparam int SEEN_W  = $clog2(ACC_W + 1);
    localparam int LEN_W   = 24;
    localparam int IDX_W   = 4;

    localparam logic [3:0]       SHORT_OFFSET_BITS = 4'd7;
    localparam logic [IDX_W-1:0] BITS_PER_BYTE     = IDX_W'(8);
    localparam logic [2:0]       EXT_MORE          = 3'd7;
    localparam logic [1:0]       CNT_MORE          = 2'd3;
    localparam logic [1:0]       SEL_WIDE          = 2'd3;
    localparam logic [2:0]       WIDE_BASE_LEN     = 3'd5;

    localparam logic [1:0] ST_BYTE      = 2'd0;
    localparam logic [1:0] ST_COMPLETE  = 2'd1;
    localparam logic [1:0] ST_CORRUPT   = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    localparam logic [2:0] CFG_OW0  = 3'd0;
    localparam logic [2:0] CFG_OW1  = 3'd1;
    localparam logic [2:0] CFG_OW2  = 3'd2;
    localparam logic [2:0] CFG_OW3  = 3'd3;
    localparam logic [2:0] CFG_ULEN = 3'd4;
    localparam logic [2:0] CFG_SKIP = 3'd5;

    typedef enum logic [3:0] {
        PH_LOAD, PH_SKIP, PH_FLAG, PH_LITCNT, PH_LITBYTE, PH_SEL,
        PH_CHOICE, PH_OFFSET, PH_EXT, PH_TAIL, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        C_IDLE, C_BIT, C_CRD, C_CWR, C_LAST, C_FLUSH
    } t_ctl_state;

    typedef struct packed {
        logic accept;
        logic bit_exec;
        logic copy_rd;
        logic copy_wr;
        logic last_exec;
        logic flush;
    } t_ctl_cmd;

    typedef struct packed {
        logic done;
        logic bits_end;
        logic copy_pending;
        logic push_ok;
        logic flush_ok;
        logic pend_v;
    } t_dp_stat;

    typedef struct packed {
        logic [7:0]       data;
        logic [LEN_W-1:0] pos;
        logic [1:0]       status;
    } t_result;

    function automatic logic [SEEN_W-1:0] clamp_width(input logic [3:0] w);
        if (w == 4'd0) begin
            return SEEN_W'(1);
        end else if (32'(w) > MAX_OFFSET_BITS) begin
            return SEEN_W'(MAX_OFFSET_BITS);
        end else begin
            return SEEN_W'(w);
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pp20_if.sv =====
`default_nettype none
interface pp20_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] crunched_byte;
    logic       final_byte;
    modport source(output valid, crunched_byte, final_byte, input ready);
    modport sink(input valid, crunched_byte, final_byte, output ready);
endinterface

interface pp20_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [23:0] out_position;
    logic [1:0]  status;
    logic        run_end;
    modport source(output valid, out_byte, out_position, status, run_end, input ready);
    modport sink(input valid, out_byte, out_position, status, run_end, output ready);
endinterface

interface pp20_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pp20_ram.sv =====
`default_nettype none
module pp20_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/pp20_ctrl.sv =====
`default_nettype none
module pp20_ctrl
    import pp20_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output t_ctl_cmd      o_cmd
);
    t_ctl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE: begin
                if (i_in_valid) n_state = C_BIT;
            end
            C_BIT: begin
                if (i_stat.copy_pending) n_state = C_CRD;
                else if (i_stat.done || i_stat.bits_end) n_state = C_LAST;
            end
            C_CRD: n_state = C_CWR;
            C_CWR: begin
                if (i_stat.push_ok) n_state = C_BIT;
            end
            C_LAST: begin
                if (i_stat.push_ok) n_state = C_FLUSH;
            end
            C_FLUSH: begin
                if (!i_stat.pend_v || i_stat.flush_ok) n_state = C_IDLE;
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            C_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            C_BIT: begin
                o_cmd.bit_exec = !i_stat.copy_pending && !i_stat.done &&
                                 !i_stat.bits_end && i_stat.push_ok;
            end
            C_CRD:   o_cmd.copy_rd   = 1'b1;
            C_CWR:   o_cmd.copy_wr   = i_stat.push_ok;
            C_LAST:  o_cmd.last_exec = i_stat.push_ok;
            C_FLUSH: o_cmd.flush     = i_stat.pend_v && i_stat.flush_ok;
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/pp20_dpath.sv =====
`default_nettype none
module pp20_dpath
    import pp20_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_ctl_cmd   i_cmd,
    output t_dp_stat        o_stat,
    input  wire logic [7:0] i_crunched_byte,
    input  wire logic       i_final_byte,
    pp20_out_if.source      o_out,
    pp20_cfg_if.sink        i_cfg
);
    logic [3:0]        r_ow0, r_ow1, r_ow2, r_ow3;
    logic [LEN_W-1:0]  r_ulen;
    logic [4:0]        r_skip_bits;

    t_phase            r_phase, n_phase;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [SEEN_W-1:0] r_seen, n_seen;
    logic [4:0]        r_skip, n_skip;
    logic [LEN_W-1:0]  r_run, n_run;
    logic [ACC_W-1:0]  r_dist, n_dist;
    logic [LEN_W-1:0]  r_left, n_left;
    logic [WR_W-1:0]   r_written, n_written;
    logic [1:0]        r_sel, n_sel;
    logic [SEEN_W-1:0] r_width, n_width;
    logic [2:0]        r_copy_cnt, n_copy_cnt;
    logic [7:0]        r_byte, n_byte;
    logic              r_final, n_final;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_pend_v, n_pend_v;
    t_result           r_pend, n_pend;
    logic              r_out_v, n_out_v;
    t_result           r_out, n_out;
    logic              r_out_end, n_out_end;

    logic              p_req;
    t_result           p_res;
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [7:0]        rdata;
    logic [LEN_W-1:0]  src_sum;
    logic              cur_bit;
    logic [ACC_W-1:0]  v;
    logic [SEEN_W-1:0] need;
    logic [SEEN_W-1:0] seen_inc;
    logic [LEN_W:0]    run_sum;
    logic [LEN_W-1:0]  run_sat;
    logic [2:0]        base_len;
    logic [2:0]        copy_len;
    logic              copy_more;
    logic [LEN_W-1:0]  left_dec;
    logic [WR_W-1:0]   written_inc;

    assign i_cfg.ready = 1'b1;
    assign src_sum     = r_left + LEN_W'(r_dist);
    assign cur_bit     = r_byte[r_idx[2:0]];
    assign v           = {r_acc[ACC_W-2:0], cur_bit};
    assign seen_inc    = r_seen + SEEN_W'(1);
    assign run_sum     = {1'b0, r_run} + (LEN_W+1)'(v[1:0]);
    assign run_sat     = run_sum[LEN_W] ? {LEN_W{1'b1}} : run_sum[LEN_W-1:0];
    assign base_len    = (r_sel == SEL_WIDE) ? WIDE_BASE_LEN : (3'(r_sel) + 3'd2);
    assign left_dec    = r_left - LEN_W'(1);
    assign written_inc = (32'(r_written) < WINDOW_DEPTH) ? r_written + WR_W'(1) : r_written;

    always_comb begin
        case (r_phase)
            PH_LITCNT, PH_SEL: need = SEEN_W'(2);
            PH_LITBYTE:        need = SEEN_W'(8);
            PH_OFFSET:         need = r_width;
            default:           need = SEEN_W'(3);
        endcase
    end

    pp20_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_window (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (i_cmd.copy_rd),
        .i_raddr(src_sum[WIN_AW-1:0]),
        .o_rdata(rdata)
    );

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_seen     = r_seen;
        n_skip     = r_skip;
        n_run      = r_run;
        n_dist     = r_dist;
        n_left     = r_left;
        n_written  = r_written;
        n_sel      = r_sel;
        n_width    = r_width;
        n_copy_cnt = r_copy_cnt;
        n_byte     = r_byte;
        n_final    = r_final;
        n_idx      = r_idx;
        p_req      = 1'b0;
        p_res      = '0;
        we         = 1'b0;
        waddr      = left_dec[WIN_AW-1:0];
        wdata      = v[7:0];
        copy_len   = 3'd0;
        copy_more  = 1'b0;

        if (i_cmd.accept) begin
            n_byte  = i_crunched_byte;
            n_final = i_final_byte;
            n_idx   = '0;
            if (r_phase == PH_LOAD) begin
                n_skip = r_skip_bits;
                n_left = r_ulen;
                if (r_ulen == '0) begin
                    p_req        = 1'b1;
                    p_res.status = ST_COMPLETE;
                    n_phase      = PH_DONE;
                end else begin
                    n_phase = (r_skip_bits != 5'd0) ? PH_SKIP : PH_FLAG;
                end
            end
        end

        if (i_cmd.bit_exec) begin
            n_idx = r_idx + IDX_W'(1);
            case (r_phase)
                PH_SKIP: begin
                    if (r_skip != 5'd0) n_skip = r_skip - 5'd1;
                    if (r_skip <= 5'd1) n_phase = PH_FLAG;
                end
                PH_FLAG: begin
                    n_acc  = '0;
                    n_seen = '0;
                    if (!cur_bit) begin
                        n_run   = LEN_W'(1);
                        n_phase = PH_LITCNT;
                    end else begin
                        n_phase = PH_SEL;
                    end
                end
                PH_CHOICE: begin
                    n_width = clamp_width(cur_bit ? r_ow3 : SHORT_OFFSET_BITS);
                    n_phase = PH_OFFSET;
                    n_acc   = '0;
                    n_seen  = '0;
                end
                default: begin
                    n_acc  = v;
                    n_seen = seen_inc;
                    if (seen_inc >= need) begin
                        n_acc  = '0;
                        n_seen = '0;
                        case (r_phase)
                            PH_LITCNT: begin
                                n_run = run_sat;
                                if (v[1:0] != CNT_MORE) begin
                                    if (run_sat > r_left) begin
                                        p_req        = 1'b1;
                                        p_res.status = ST_CORRUPT;
                                        n_phase      = PH_DONE;
                                    end else begin
                                        n_phase = PH_LITBYTE;
                                    end
                                end
                            end
                            PH_LITBYTE: begin
                                we           = 1'b1;
                                p_req        = 1'b1;
                                p_res.data   = v[7:0];
                                p_res.pos    = left_dec;
                                p_res.status = (left_dec == '0) ? ST_COMPLETE : ST_BYTE;
                                n_left       = left_dec;
                                n_written    = written_inc;
                                if (r_run != '0) n_run = r_run - LEN_W'(1);
                                if (left_dec == '0) n_phase = PH_DONE;
                                else if (r_run <= LEN_W'(1)) n_phase = PH_SEL;
                            end
                            PH_SEL: begin
                                n_sel = v[1:0];
                                if (v[1:0] != SEL_WIDE) begin
                                    case (v[1:0])
                                        2'd0:    n_width = clamp_width(r_ow0);
                                        2'd1:    n_width = clamp_width(r_ow1);
                                        default: n_width = clamp_width(r_ow2);
                                    endcase
                                    n_phase = PH_OFFSET;
                                end else begin
                                    n_phase = PH_CHOICE;
                                end
                            end
                            PH_OFFSET: begin
                                n_dist = v;
                                if (32'(v) >= 32'(r_written) || LEN_W'(base_len) > r_left)
                                begin
                                    p_req        = 1'b1;
                                    p_res.status = ST_CORRUPT;
                                    n_phase      = PH_DONE;
                                end else begin
                                    copy_len  = base_len;
                                    copy_more = (r_sel == SEL_WIDE);
                                end
                            end
                            PH_EXT: begin
                                if (LEN_W'(v[2:0]) > r_left) begin
                                    p_req        = 1'b1;
                                    p_res.status = ST_CORRUPT;
                                    n_phase      = PH_DONE;
                                end else begin
                                    copy_len  = v[2:0];
                                    copy_more = (v[2:0] == EXT_MORE);
                                end
                            end
                            PH_TAIL: begin
                                if (v[2:0] != 3'd0) begin
                                    p_req        = 1'b1;
                                    p_res.status = ST_CORRUPT;
                                end
                                n_phase = PH_DONE;
                            end
                            default: n_phase = r_phase;
                        endcase
                        // settle the phase after the copy now: the length was checked
                        if (r_phase == PH_EXT || r_phase == PH_OFFSET) begin
                            if (n_phase != PH_DONE) begin
                                n_copy_cnt = copy_len;
                                if (r_left == LEN_W'(copy_len)) begin
                                    n_phase = copy_more ? PH_TAIL : PH_DONE;
                                end else begin
                                    n_phase = copy_more ? PH_EXT : PH_FLAG;
                                end
                            end
                        end
                    end
                end
            endcase
        end

        if (i_cmd.copy_wr) begin
            we           = 1'b1;
            wdata        = rdata;
            p_req        = 1'b1;
            p_res.data   = rdata;
            p_res.pos    = left_dec;
            p_res.status = (left_dec == '0) ? ST_COMPLETE : ST_BYTE;
            n_left       = left_dec;
            n_written    = written_inc;
            n_copy_cnt   = r_copy_cnt - 3'd1;
        end

        if (i_cmd.last_exec && r_final && r_phase != PH_DONE) begin
            if (r_phase != PH_TAIL) begin
                p_req        = 1'b1;
                p_res.status = ST_EXHAUSTED;
            end
            n_phase = PH_DONE;
        end
    end

    always_comb begin
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        n_out_v   = r_out_v && !o_out.ready;
        n_out     = r_out;
        n_out_end = r_out_end;
        if (p_req) begin
            if (r_pend_v) begin
                n_out_v   = 1'b1;
                n_out     = r_pend;
                n_out_end = 1'b0;
            end
            n_pend_v = 1'b1;
            n_pend   = p_res;
        end
        if (i_cmd.flush) begin
            n_out_v   = 1'b1;
            n_out     = r_pend;
            n_out_end = 1'b1;
            n_pend_v  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ow0       <= 4'd9;
            r_ow1       <= 4'd10;
            r_ow2       <= 4'd11;
            r_ow3       <= 4'd11;
            r_ulen      <= LEN_W'(1);
            r_skip_bits <= 5'd0;
            r_phase     <= PH_LOAD;
            r_acc       <= '0;
            r_seen      <= '0;
            r_skip      <= '0;
            r_run       <= '0;
            r_dist      <= '0;
            r_left      <= '0;
            r_written   <= '0;
            r_sel       <= '0;
            r_width     <= SEEN_W'(1);
            r_copy_cnt  <= '0;
            r_idx       <= '0;
            r_final     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_OW0:  r_ow0       <= i_cfg.data[3:0];
                    CFG_OW1:  r_ow1       <= i_cfg.data[3:0];
                    CFG_OW2:  r_ow2       <= i_cfg.data[3:0];
                    CFG_OW3:  r_ow3       <= i_cfg.data[3:0];
                    CFG_ULEN: r_ulen      <= i_cfg.data;
                    CFG_SKIP: r_skip_bits <= i_cfg.data[4:0];
                    default:  r_ulen      <= r_ulen;
                endcase
            end
            r_phase    <= n_phase;
            r_acc      <= n_acc;
            r_seen     <= n_seen;
            r_skip     <= n_skip;
            r_run      <= n_run;
            r_dist     <= n_dist;
            r_left     <= n_left;
            r_written  <= n_written;
            r_sel      <= n_sel;
            r_width    <= n_width;
            r_copy_cnt <= n_copy_cnt;
            r_idx      <= n_idx;
            r_final    <= n_final;
            r_pend_v   <= n_pend_v;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_pend    <= n_pend;
        r_out     <= n_out;
        r_out_end <= n_out_end;
    end

    assign o_stat.done         = (r_phase == PH_DONE);
    assign o_stat.bits_end     = (r_idx == BITS_PER_BYTE);
    assign o_stat.copy_pending = (r_copy_cnt != 3'd0);
    assign o_stat.push_ok      = !r_pend_v || !r_out_v || o_out.ready;
    assign o_stat.flush_ok     = !r_out_v || o_out.ready;
    assign o_stat.pend_v       = r_pend_v;

    assign o_out.valid        = r_out_v;
    assign o_out.out_byte     = r_out.data;
    assign o_out.out_position = r_out.pos;
    assign o_out.status       = r_out.status;
    assign o_out.run_end      = r_out_end;
endmodule
`default_nettype wire

// ===== rtl/pp20_backward_lz_decruncher.sv =====
`default_nettype none
// Channel  Dir  Handshake      Payload
// i_in     in   valid/ready    crunched_byte[7:0], final_byte
// o_out    out  valid/ready    out_byte[7:0], out_position[23:0], status[1:0], run_end
// i_cfg    in   valid/ready    index[2:0], data[23:0] (ready always high)
//
// A crunched byte without copies passes accept, a step for each stream bit, the
// end-of-input step and the flush of its last request; once the stream has ended a
// byte skips its bit steps. Each copied byte adds a dispatch, a window read, then a
// write and request. The single-port-read history window sets the copy cost.
// Reset is synchronous, active low; the window is not cleared.
// A full output register stalls bit decoding and copying until it drains.
module pp20_backward_lz_decruncher
    import pp20_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pp20_in_if.sink    i_in,
    pp20_out_if.source o_out,
    pp20_cfg_if.sink   i_cfg
);
    t_ctl_cmd cmd;
    t_dp_stat stat;
    logic     in_ready;

    assign i_in.ready = in_ready;

    // sequence each byte: accept, walk its bits, run copies, flush the last request
    pp20_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .i_stat    (stat),
        .o_in_ready(in_ready),
        .o_cmd     (cmd)
    );

    // decode state, history window, and output staging
    pp20_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_crunched_byte(i_in.crunched_byte),
        .i_final_byte   (i_in.final_byte),
        .o_out          (o_out),
        .i_cfg          (i_cfg)
    );
endmodule
`default_nettype wire
